// ===== design/bb_pkg.sv =====
`timescale 1ns / 1ps
package bb_pkg;

    // Frame geometry
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int FW_W       = 11;                       // frame_width register
    localparam int FH_W       = 13;                       // frame_height register
    localparam int COL_W      = $clog2(MAX_WIDTH);        // column counter / line store index
    localparam int ROW_W      = $clog2(MAX_HEIGHT);       // row counter
    localparam int EW_W       = (FW_W > $clog2(MAX_WIDTH + 1)) ? FW_W : $clog2(MAX_WIDTH + 1);
    localparam int EH_W       = FH_W;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = FH_W;
    localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = FW_W'(1024);
    localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = FH_W'(768);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } cfg_reg_t;

    // Datapath widths
    localparam int PIX_W = 24;
    localparam int SUM_W = 12;    // up to nine 8-bit values
    localparam int CNT_W = 4;     // 1..9 neighbors

    // Reciprocal constants for the rounded mean, exact for the value range used
    localparam int RCP_SH  = 14;
    localparam int RCP_W   = 13;
    localparam logic [RCP_W-1:0] RCP_DIV3 = RCP_W'(5462);   // ceil(2^14 / 3)
    localparam logic [RCP_W-1:0] RCP_DIV9 = RCP_W'(1821);   // ceil(2^14 / 9)
    localparam int PROD_W  = SUM_W + RCP_W;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    // Line store word: row two above and row just above, same column
    typedef struct packed {
        pixel_t older;
        pixel_t prev;
    } lb_word_t;

    // Position flags of an input pixel within the frame
    typedef struct packed {
        logic r_ge1;
        logic r_ge2;
        logic c_ge1;
        logic c_ge2;
        logic last_row;
        logic last_col;
    } pos_t;

    // New window column plus its position
    typedef struct packed {
        pixel_t older;
        pixel_t prev;
        pixel_t px;
        pos_t   pos;
    } lb_out_t;

    // Neighborhood sums for one result
    typedef struct packed {
        logic [SUM_W-1:0] red;
        logic [SUM_W-1:0] green;
        logic [SUM_W-1:0] blue;
        logic [CNT_W-1:0] cnt;
        logic             last;
        logic             frame_done;
    } sum_t;

    // Rounded-half-up mean: (2*s + n) / (2*n), n in {1,2,3,4,6,9}.
    // Powers of two shift; the /3 and /9 cases use a reciprocal multiply.
    function automatic logic [7:0] mean_round(logic [SUM_W-1:0] s, logic [CNT_W-1:0] n);
        logic [SUM_W:0]    x;
        logic [SUM_W-1:0]  y;
        logic [PROD_W-1:0] p;
        logic [7:0]        q;
        x = {s, 1'b0} + (SUM_W + 1)'(n);
        y = '0;
        p = '0;
        unique case (n)
            4'd1: q = 8'(x >> 1);
            4'd2: q = 8'(x >> 2);
            4'd4: q = 8'(x >> 3);
            4'd3: begin
                y = SUM_W'(x >> 1);
                p = PROD_W'(y) * PROD_W'(RCP_DIV3);
                q = p[RCP_SH+7:RCP_SH];
            end
            4'd6: begin
                y = SUM_W'(x >> 2);
                p = PROD_W'(y) * PROD_W'(RCP_DIV3);
                q = p[RCP_SH+7:RCP_SH];
            end
            4'd9: begin
                y = SUM_W'(x >> 1);
                p = PROD_W'(y) * PROD_W'(RCP_DIV9);
                q = p[RCP_SH+7:RCP_SH];
            end
            default: q = 8'(x >> 1);
        endcase
        return q;
    endfunction

endpackage

// ===== design/bb_line_buf.sv =====
`timescale 1ns / 1ps
module bb_line_buf (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  bb_pkg::pixel_t            in_px,
    input  logic [bb_pkg::COL_W-1:0]  in_col,
    input  bb_pkg::pos_t              in_pos,
    output logic                      out_valid,
    input  logic                      out_ready,
    output bb_pkg::lb_out_t           out_data
);
    import bb_pkg::*;

    lb_word_t           mem [MAX_WIDTH];
    lb_word_t           rd_reg;
    logic               s1_valid_reg;
    pixel_t             s1_px_reg;
    logic [COL_W-1:0]   s1_col_reg;
    pos_t               s1_pos_reg;

    logic               in_fire;
    logic               out_fire;
    logic               bypass;
    lb_word_t           wr_word;

    assign out_fire = s1_valid_reg & out_ready;
    assign in_ready = ~s1_valid_reg | out_ready;
    assign in_fire  = in_valid & in_ready;

    // Each column shifts down one row: prev becomes older, new pixel becomes prev
    assign wr_word = '{older: rd_reg.prev, prev: s1_px_reg};

    // Same column read while it is being written (one-pixel rows)
    assign bypass = out_fire & (s1_col_reg == in_col);

    // Line store write
    always_ff @(posedge aclk) begin
        if (out_fire) begin
            mem[s1_col_reg] <= wr_word;
        end
    end

    // Registered read with write bypass
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            rd_reg     <= bypass ? wr_word : mem[in_col];
            s1_px_reg  <= in_px;
            s1_col_reg <= in_col;
            s1_pos_reg <= in_pos;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (in_fire) begin
            s1_valid_reg <= 1'b1;
        end else if (out_fire) begin
            s1_valid_reg <= 1'b0;
        end
    end

    assign out_valid = s1_valid_reg;
    assign out_data  = '{older: rd_reg.older, prev: rd_reg.prev, px: s1_px_reg, pos: s1_pos_reg};

endmodule

// ===== design/bb_window.sv =====
`timescale 1ns / 1ps
module bb_window (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  bb_pkg::lb_out_t  in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output bb_pkg::sum_t     out_sum
);
    import bb_pkg::*;

    // Result kinds, in output order
    localparam int KIND_UP_LEFT  = 0;   // (r-1, c-1)
    localparam int KIND_UP_HERE  = 1;   // (r-1, c)
    localparam int KIND_CUR_LEFT = 2;   // (r, c-1)
    localparam int KIND_CUR_HERE = 3;   // (r, c)
    localparam int RS_W = 10;           // sum of three 8-bit values

    // Window: row 0 oldest, column 2 newest
    pixel_t           win_reg [3][3];
    logic             job_valid_reg;
    logic [3:0]       job_mask_reg;
    pos_t             job_pos_reg;
    logic             sum_valid_reg;
    sum_t             sum_reg;

    logic             in_fire;
    logic             emit_fire;
    logic             job_done;
    logic             sum_ready;
    logic [3:0]       new_mask;
    logic [3:0]       pick;
    logic [3:0]       rest;
    logic             row_prev;
    logic             col_prev;
    logic [2:0]       row_inc;
    logic [2:0]       col_inc;
    logic [1:0]       nrows;
    logic [1:0]       ncols;
    logic [RS_W-1:0]  rs_red   [3];
    logic [RS_W-1:0]  rs_green [3];
    logic [RS_W-1:0]  rs_blue  [3];
    sum_t             sum_next;

    assign sum_ready = ~sum_valid_reg | out_ready;
    assign emit_fire = job_valid_reg & sum_ready;

    // Pick the next pending result, lowest kind first
    always_comb begin
        pick     = job_mask_reg & (~job_mask_reg + 4'd1);
        rest     = job_mask_reg & ~pick;
        row_prev = pick[KIND_UP_LEFT] | pick[KIND_UP_HERE];
        col_prev = pick[KIND_UP_LEFT] | pick[KIND_CUR_LEFT];
    end

    assign job_done = emit_fire & (rest == 4'd0);
    assign in_ready = ~job_valid_reg | job_done;
    assign in_fire  = in_valid & in_ready;

    // Results this pixel completes
    always_comb begin
        new_mask                = '0;
        new_mask[KIND_UP_LEFT]  = in_data.pos.r_ge1 & in_data.pos.c_ge1;
        new_mask[KIND_UP_HERE]  = in_data.pos.r_ge1 & in_data.pos.last_col;
        new_mask[KIND_CUR_LEFT] = in_data.pos.last_row & in_data.pos.c_ge1;
        new_mask[KIND_CUR_HERE] = in_data.pos.last_row & in_data.pos.last_col;
    end

    // Neighbors inside the frame for the picked result
    always_comb begin
        row_inc = row_prev ? {1'b1, 1'b1, job_pos_reg.r_ge2} : {1'b1, job_pos_reg.r_ge1, 1'b0};
        col_inc = col_prev ? {1'b1, 1'b1, job_pos_reg.c_ge2} : {1'b1, job_pos_reg.c_ge1, 1'b0};
        nrows   = 2'(row_inc[0]) + 2'(row_inc[1]) + 2'(row_inc[2]);
        ncols   = 2'(col_inc[0]) + 2'(col_inc[1]) + 2'(col_inc[2]);
    end

    // Row sums, then total
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            rs_red[i]   = '0;
            rs_green[i] = '0;
            rs_blue[i]  = '0;
            for (int j = 0; j < 3; j++) begin
                if (row_inc[i] & col_inc[j]) begin
                    rs_red[i]   = rs_red[i]   + RS_W'(win_reg[i][j].red);
                    rs_green[i] = rs_green[i] + RS_W'(win_reg[i][j].green);
                    rs_blue[i]  = rs_blue[i]  + RS_W'(win_reg[i][j].blue);
                end
            end
        end
        sum_next.red   = SUM_W'(rs_red[0])   + SUM_W'(rs_red[1])   + SUM_W'(rs_red[2]);
        sum_next.green = SUM_W'(rs_green[0]) + SUM_W'(rs_green[1]) + SUM_W'(rs_green[2]);
        sum_next.blue  = SUM_W'(rs_blue[0])  + SUM_W'(rs_blue[1])  + SUM_W'(rs_blue[2]);
        sum_next.cnt        = CNT_W'(nrows) * CNT_W'(ncols);
        sum_next.last       = (rest == 4'd0);
        sum_next.frame_done = pick[KIND_CUR_HERE];
    end

    // Window shift on each new column
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            for (int i = 0; i < 3; i++) begin
                win_reg[i][0] <= win_reg[i][1];
                win_reg[i][1] <= win_reg[i][2];
            end
            win_reg[0][2] <= in_data.older;
            win_reg[1][2] <= in_data.prev;
            win_reg[2][2] <= in_data.px;
            job_pos_reg   <= in_data.pos;
        end
    end

    // Pending results of the current window
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            job_valid_reg <= 1'b0;
            job_mask_reg  <= '0;
        end else if (in_fire) begin
            job_valid_reg <= (new_mask != 4'd0);
            job_mask_reg  <= new_mask;
        end else if (emit_fire) begin
            job_valid_reg <= (rest != 4'd0);
            job_mask_reg  <= rest;
        end
    end

    // Sum register
    always_ff @(posedge aclk) begin
        if (emit_fire) begin
            sum_reg <= sum_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_valid_reg <= 1'b0;
        end else if (emit_fire) begin
            sum_valid_reg <= 1'b1;
        end else if (out_ready) begin
            sum_valid_reg <= 1'b0;
        end
    end

    assign out_valid = sum_valid_reg;
    assign out_sum   = sum_reg;

endmodule

// ===== design/bb_mean.sv =====
`timescale 1ns / 1ps
module bb_mean (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  bb_pkg::sum_t  in_sum,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [23:0]   m_tdata,    // red_out, green_out, blue_out
    output logic          m_tlast,    // last_of_run
    output logic [0:0]    m_tuser     // frame_done
);
    import bb_pkg::*;

    logic       out_valid_reg;
    pixel_t     out_px_reg;
    logic       out_last_reg;
    logic       out_done_reg;
    logic       in_fire;

    assign in_ready = ~out_valid_reg | m_tready;
    assign in_fire  = in_valid & in_ready;

    // Rounded means into the output register
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            out_px_reg.red   <= mean_round(in_sum.red,   in_sum.cnt);
            out_px_reg.green <= mean_round(in_sum.green, in_sum.cnt);
            out_px_reg.blue  <= mean_round(in_sum.blue,  in_sum.cnt);
            out_last_reg     <= in_sum.last;
            out_done_reg     <= in_sum.frame_done;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (in_fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = {out_px_reg.blue, out_px_reg.green, out_px_reg.red};
    assign m_tlast    = out_last_reg;
    assign m_tuser[0] = out_done_reg;

endmodule

// ===== design/box_blur_3x3_rgb.sv =====
`timescale 1ns / 1ps
// 3x3 box blur on an RGB raster stream.
// Input: one pixel per request on s_*, raster order, frame_width x frame_height
// set through the write port (cfg_addr 0 = width, 1 = height). A write restarts
// the frame at row 0, column 0; write only while the block is idle.
// Output: one filtered pixel per request on m_*, raster order. m_tlast marks the
// last result caused by an input pixel, m_tuser[0] the bottom-right pixel.
// Results lag their input by one row and one column, so a row end yields two
// results and the last row up to four for one input pixel.
// Path: an input is registered in the line store read stage, then in the window,
// the sum register and the output register. Throughput: one input per cycle while
// each input gives at most one result and m_* is not stalled; the window stage
// emits one result per cycle unless stalled, holding input until its results are out.
// Reset: clears all valid flags, counters and sets width 1024, height 768.
// The line store is not cleared; stale entries only fall outside the frame.
// Receiver stall: m_* holds, and back pressure reaches s_tready once the
// pipeline registers fill (at most four items in flight).
module box_blur_3x3_rgb (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [23:0]                    s_tdata,    // red_in, green_in, blue_in
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [23:0]                    m_tdata,    // red_out, green_out, blue_out
    output logic                           m_tlast,    // last_of_run
    output logic [0:0]                     m_tuser,    // frame_done
    input  logic                           cfg_wr_en,
    input  logic [bb_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  logic [bb_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import bb_pkg::*;

    logic [FW_W-1:0]   frame_width_reg;
    logic [FH_W-1:0]   frame_height_reg;
    logic [COL_W-1:0]  col_reg;
    logic [ROW_W-1:0]  row_reg;

    logic [EW_W-1:0]   w_ext;
    logic [EW_W-1:0]   eff_w;
    logic [EH_W-1:0]   eff_h;
    logic              s_fire;
    pixel_t            in_px;
    pos_t              in_pos;

    logic              lb_valid;
    logic              lb_ready;
    lb_out_t           lb_data;
    logic              sum_valid;
    logic              sum_ready;
    sum_t              sum_data;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_wdata[FW_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_wdata[FH_W-1:0];
            endcase
        end
    end

    // Effective frame size: zero reads as one, oversize saturates
    always_comb begin
        w_ext = EW_W'(frame_width_reg);
        priority if (w_ext == '0) begin
            eff_w = EW_W'(1);
        end else if (w_ext > EW_W'(MAX_WIDTH)) begin
            eff_w = EW_W'(MAX_WIDTH);
        end else begin
            eff_w = w_ext;
        end
        priority if (frame_height_reg == '0) begin
            eff_h = EH_W'(1);
        end else if (frame_height_reg > EH_W'(MAX_HEIGHT)) begin
            eff_h = EH_W'(MAX_HEIGHT);
        end else begin
            eff_h = frame_height_reg;
        end
    end

    // Position flags of the incoming pixel
    always_comb begin
        in_pos.r_ge1    = (row_reg != '0);
        in_pos.r_ge2    = (row_reg > ROW_W'(1));
        in_pos.c_ge1    = (col_reg != '0);
        in_pos.c_ge2    = (col_reg > COL_W'(1));
        in_pos.last_col = (EW_W'(col_reg) == (eff_w - EW_W'(1)));
        in_pos.last_row = (EH_W'(row_reg) == (eff_h - EH_W'(1)));
        in_px.red       = s_tdata[7:0];
        in_px.green     = s_tdata[15:8];
        in_px.blue      = s_tdata[23:16];
    end

    assign s_fire = s_tvalid & s_tready;

    // Raster position counters
    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_wr_en) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (s_fire) begin
            if (in_pos.last_col) begin
                col_reg <= '0;
                row_reg <= in_pos.last_row ? '0 : row_reg + ROW_W'(1);
            end else begin
                col_reg <= col_reg + COL_W'(1);
            end
        end
    end

    bb_line_buf u_line_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_px     (in_px),
        .in_col    (col_reg),
        .in_pos    (in_pos),
        .out_valid (lb_valid),
        .out_ready (lb_ready),
        .out_data  (lb_data)
    );

    bb_window u_window (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (lb_valid),
        .in_ready  (lb_ready),
        .in_data   (lb_data),
        .out_valid (sum_valid),
        .out_ready (sum_ready),
        .out_sum   (sum_data)
    );

    bb_mean u_mean (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (sum_valid),
        .in_ready  (sum_ready),
        .in_sum    (sum_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule

// ===== design/bb_checker.sv =====
`timescale 1ns / 1ps
module bb_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,
    input  logic        m_tlast,
    input  logic [0:0]  m_tuser
);

    // A stalled result holds its contents
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
                                  && $stable(m_tuser))
        else $error("stalled result changed");

    // The bottom-right pixel is always the last result of its input
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tlast)
        else $error("frame end without end of run");

    // Reset empties the output register
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // Reset leaves the input side free to take a request
    assert property (@(posedge aclk) !aresetn |=> s_tready)
        else $error("input not ready after reset");

endmodule

bind box_blur_3x3_rgb bb_checker u_bb_checker (.*);
